// ----- sv/tld_pkg.sv -----
// Shared package for the type-length-value deframer.
// Holds framing constants, register indexes, error codes and the transaction payload types.
// No dependencies.
package tld_pkg;

    localparam int TYPE_BYTES   = 4;
    localparam int LENGTH_BYTES = 4;
    localparam int TYPE_SLOTS   = 4;

    localparam int NAME_REGS = 4;
    localparam int BYTE_W    = 8;
    localparam int NAME_W    = 32;
    localparam int LEN_W     = 32;
    localparam int TYPE_W    = 3;
    localparam int ERR_W     = 2;
    localparam int DATA_W    = 32;
    localparam int INDEX_W   = 3;

    localparam int HDR_MAX = (TYPE_BYTES > LENGTH_BYTES) ? TYPE_BYTES : LENGTH_BYTES;
    localparam int HDR_W   = $clog2(HDR_MAX + 1);

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 32'd65536;

    localparam logic [INDEX_W-1:0] REG_TYPE_COUNT      = 3'd0;
    localparam logic [INDEX_W-1:0] REG_TYPE_NAME_ONE   = 3'd1;
    localparam logic [INDEX_W-1:0] REG_TYPE_NAME_TWO   = 3'd2;
    localparam logic [INDEX_W-1:0] REG_TYPE_NAME_THREE = 3'd3;
    localparam logic [INDEX_W-1:0] REG_TYPE_NAME_FOUR  = 3'd4;
    localparam logic [INDEX_W-1:0] REG_MAX_PAYLOAD     = 3'd5;

    localparam logic [ERR_W-1:0] ERR_NONE         = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN_TYPE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_LENGTH       = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] stream_byte;
        logic              restart;
    } item_t;

    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic [TYPE_W-1:0] message_type;
        logic              message_end;
        logic [ERR_W-1:0]  error_code;
        logic              in_error;
    } result_t;

endpackage

// ----- sv/type_length_value_deframer.sv -----
// Type-length-value deframer: one stream byte per transaction, one result per transaction.
// An accepted item's result is written into the output register.
// Throughput is one item per cycle unless the output register is full and result_ready is low;
// the output register lets a new item in while it drains. Asynchronous active-low reset clears
// the parser to the type name phase, empties the output register and restores the configuration
// registers to their reset values. Depends on tld_pkg.
module type_length_value_deframer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            write_enable,
    input  logic [tld_pkg::INDEX_W-1:0]     write_index,
    input  logic [tld_pkg::DATA_W-1:0]      write_data,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  tld_pkg::item_t                  item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output tld_pkg::result_t                result
);

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_DATA,
        PH_ERR
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [tld_pkg::HDR_W-1:0]       header_count_reg, header_count_next;
    logic [tld_pkg::NAME_W-1:0]      type_shift_reg, type_shift_next;
    logic [tld_pkg::LEN_W-1:0]       declared_length_reg, declared_length_next;
    logic [tld_pkg::LEN_W-1:0]       received_count_reg, received_count_next;
    logic [tld_pkg::TYPE_W-1:0]      current_type_reg, current_type_next;

    logic [tld_pkg::TYPE_W-1:0]      type_count_reg;
    logic [tld_pkg::NAME_W-1:0]      type_name_reg [tld_pkg::NAME_REGS];
    logic [tld_pkg::LEN_W-1:0]       max_payload_reg;

    logic                            result_valid_reg, result_valid_next;
    tld_pkg::result_t                result_reg, result_next;

    logic                            accept;
    logic [tld_pkg::NAME_W-1:0]      shift_base;
    logic [tld_pkg::NAME_W-1:0]      shift_in;
    logic [tld_pkg::LEN_W-1:0]       length_in;
    logic [tld_pkg::LEN_W-1:0]       received_inc;
    logic [tld_pkg::HDR_W-1:0]       count_inc;
    logic [tld_pkg::TYPE_W-1:0]      slot_count;
    logic [tld_pkg::TYPE_W-1:0]      matched_type;

    assign item_ready   = !result_valid_reg || result_ready;
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        shift_base   = (header_count_reg == '0) ? '0 : type_shift_reg;
        shift_in     = {shift_base[tld_pkg::NAME_W-tld_pkg::BYTE_W-1:0], item.stream_byte};
        length_in    = {declared_length_reg[tld_pkg::LEN_W-tld_pkg::BYTE_W-1:0],
                        item.stream_byte};
        received_inc = received_count_reg + 1'b1;
        count_inc    = header_count_reg + 1'b1;
        slot_count   = (type_count_reg > tld_pkg::TYPE_W'(tld_pkg::TYPE_SLOTS))
                       ? tld_pkg::TYPE_W'(tld_pkg::TYPE_SLOTS) : type_count_reg;
        matched_type = '0;
        for (int i = tld_pkg::TYPE_SLOTS - 1; i >= 0; i--)
        begin
            if ((tld_pkg::TYPE_W'(i) < slot_count) && (type_name_reg[i] == shift_in))
            begin
                matched_type = tld_pkg::TYPE_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        phase_next           = phase_reg;
        header_count_next    = header_count_reg;
        type_shift_next      = type_shift_reg;
        declared_length_next = declared_length_reg;
        received_count_next  = received_count_reg;
        current_type_next    = current_type_reg;
        result_next          = result_reg;
        result_valid_next    = result_valid_reg && !result_ready;

        if (accept)
        begin
            result_valid_next = 1'b1;
            result_next       = '0;
            if (item.restart)
            begin
                phase_next           = PH_TYPE;
                header_count_next    = '0;
                type_shift_next      = '0;
                declared_length_next = '0;
                received_count_next  = '0;
                current_type_next    = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_ERR:
                    begin
                        result_next.in_error = 1'b1;
                    end
                    PH_LEN:
                    begin
                        declared_length_next     = length_in;
                        header_count_next        = count_inc;
                        result_next.message_type = current_type_reg;
                        if (header_count_reg == tld_pkg::HDR_W'(tld_pkg::LENGTH_BYTES - 1))
                        begin
                            header_count_next = '0;
                            if (length_in > max_payload_reg)
                            begin
                                result_next.error_code = tld_pkg::ERR_LENGTH;
                                result_next.in_error   = 1'b1;
                                phase_next             = PH_ERR;
                                current_type_next      = '0;
                            end
                            else if (length_in == '0)
                            begin
                                result_next.message_end = 1'b1;
                                phase_next              = PH_TYPE;
                                type_shift_next         = '0;
                                declared_length_next    = '0;
                                received_count_next     = '0;
                                current_type_next       = '0;
                            end
                            else
                            begin
                                received_count_next = '0;
                                phase_next          = PH_DATA;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        result_next.payload_valid = 1'b1;
                        result_next.payload_byte  = item.stream_byte;
                        result_next.message_type  = current_type_reg;
                        received_count_next       = received_inc;
                        if (received_inc >= declared_length_reg)
                        begin
                            result_next.message_end = 1'b1;
                            phase_next              = PH_TYPE;
                            header_count_next       = '0;
                            type_shift_next         = '0;
                            declared_length_next    = '0;
                            received_count_next     = '0;
                            current_type_next       = '0;
                        end
                    end
                    default:
                    begin
                        type_shift_next   = shift_in;
                        header_count_next = count_inc;
                        if (header_count_reg == tld_pkg::HDR_W'(tld_pkg::TYPE_BYTES - 1))
                        begin
                            header_count_next = '0;
                            if (matched_type == '0)
                            begin
                                result_next.error_code = tld_pkg::ERR_UNKNOWN_TYPE;
                                result_next.in_error   = 1'b1;
                                phase_next             = PH_ERR;
                            end
                            else
                            begin
                                current_type_next        = matched_type;
                                result_next.message_type = matched_type;
                                declared_length_next     = '0;
                                received_count_next      = '0;
                                phase_next               = PH_LEN;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_TYPE;
            header_count_reg    <= '0;
            type_shift_reg      <= '0;
            declared_length_reg <= '0;
            received_count_reg  <= '0;
            current_type_reg    <= '0;
            type_count_reg      <= '0;
            for (int i = 0; i < tld_pkg::NAME_REGS; i++)
            begin
                type_name_reg[i] <= '0;
            end
            max_payload_reg     <= tld_pkg::MAX_PAYLOAD_RESET;
            result_valid_reg    <= 1'b0;
            result_reg          <= '0;
        end
        else
        begin
            phase_reg           <= phase_next;
            header_count_reg    <= header_count_next;
            type_shift_reg      <= type_shift_next;
            declared_length_reg <= declared_length_next;
            received_count_reg  <= received_count_next;
            current_type_reg    <= current_type_next;
            result_valid_reg    <= result_valid_next;
            result_reg          <= result_next;
            if (write_enable)
            begin
                case (write_index)
                    tld_pkg::REG_TYPE_COUNT:
                        type_count_reg <= write_data[tld_pkg::TYPE_W-1:0];
                    tld_pkg::REG_TYPE_NAME_ONE:
                        type_name_reg[0] <= write_data[tld_pkg::NAME_W-1:0];
                    tld_pkg::REG_TYPE_NAME_TWO:
                        type_name_reg[1] <= write_data[tld_pkg::NAME_W-1:0];
                    tld_pkg::REG_TYPE_NAME_THREE:
                        type_name_reg[2] <= write_data[tld_pkg::NAME_W-1:0];
                    tld_pkg::REG_TYPE_NAME_FOUR:
                        type_name_reg[3] <= write_data[tld_pkg::NAME_W-1:0];
                    tld_pkg::REG_MAX_PAYLOAD:
                        max_payload_reg <= write_data[tld_pkg::LEN_W-1:0];
                    default:
                        ;
                endcase
            end
        end
    end

    // A message's type number lives only from the type match through the payload.
    a_type_cleared_outside_message: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TYPE || phase_reg == PH_ERR) |-> current_type_reg == '0)
        else $error("type number held outside a message");

    a_count_below_length: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> received_count_reg < declared_length_reg)
        else $error("payload count reached the declared length without ending");

    a_error_is_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !item.restart && phase_reg == PH_ERR)
        |=> (phase_reg == PH_ERR && result_valid_reg && result_reg.in_error))
        else $error("error state left without restart");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.restart)
        |=> (phase_reg == PH_TYPE && header_count_reg == '0 && result_reg == '0))
        else $error("restart did not clear the parser");

    a_payload_without_error: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.payload_valid)
        |-> (result_reg.error_code == tld_pkg::ERR_NONE && !result_reg.in_error
             && result_reg.message_type != '0))
        else $error("payload transaction carries an error or no type");

endmodule

// ----- bench/type_length_value_deframer_checker.sv -----
// Checker for the type-length-value deframer: watches the register port and both channels,
// predicts every result from the accepted stream bytes and compares each accepted result.
// Depends on tld_pkg.
module type_length_value_deframer_checker
    import tld_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               write_enable,
    input  logic [INDEX_W-1:0] write_index,
    input  logic [DATA_W-1:0]  write_data,
    input  logic               item_valid,
    input  logic               item_ready,
    input  item_t              item,
    input  logic               result_valid,
    input  logic               result_ready,
    input  result_t            result,
    output int                 failures,
    output int                 pending,
    output int                 results_checked,
    output int                 messages_ended
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {SEEK_TYPE, SEEK_LENGTH, PASS_PAYLOAD, HOLD_ERROR} parse_phase_t;

    logic [2:0]        slots_enabled;
    logic [NAME_W-1:0] type_names [NAME_REGS];
    logic [LEN_W-1:0]  payload_cap;

    parse_phase_t      parse_phase;
    int unsigned       header_bytes;
    logic [NAME_W-1:0] name_shift;
    logic [LEN_W-1:0]  declared_len;
    logic [LEN_W-1:0]  received_len;
    logic [TYPE_W-1:0] active_type;

    result_t           awaited_results [$];

    function automatic logic [TYPE_W-1:0] lookup_type(input logic [NAME_W-1:0] name);
        int limit;
        limit = (slots_enabled > TYPE_SLOTS) ? TYPE_SLOTS : int'(slots_enabled);
        for (int i = 0; i < limit; i++)
        begin
            if (type_names[i] == name)
            begin
                return TYPE_W'(i + 1);
            end
        end
        return '0;
    endfunction

    task automatic clear_parse();
        parse_phase  = SEEK_TYPE;
        header_bytes = 0;
        name_shift   = '0;
        declared_len = '0;
        received_len = '0;
        active_type  = '0;
    endtask

    task automatic deframe_byte(input item_t it, output result_t r);
        logic [TYPE_W-1:0] matched;
        r = '0;
        if (it.restart)
        begin
            clear_parse();
        end
        else
        begin
            case (parse_phase)
                HOLD_ERROR:
                begin
                    r.in_error = 1'b1;
                end
                SEEK_LENGTH:
                begin
                    declared_len = {declared_len[LEN_W-BYTE_W-1:0], it.stream_byte};
                    header_bytes++;
                    r.message_type = active_type;
                    if (header_bytes >= LENGTH_BYTES)
                    begin
                        header_bytes = 0;
                        if (declared_len > payload_cap)
                        begin
                            r.error_code = ERR_LENGTH;
                            r.in_error   = 1'b1;
                            parse_phase  = HOLD_ERROR;
                            active_type  = '0;
                        end
                        else if (declared_len == '0)
                        begin
                            r.message_end = 1'b1;
                            clear_parse();
                        end
                        else
                        begin
                            received_len = '0;
                            parse_phase  = PASS_PAYLOAD;
                        end
                    end
                end
                PASS_PAYLOAD:
                begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = it.stream_byte;
                    r.message_type  = active_type;
                    received_len++;
                    if (received_len >= declared_len)
                    begin
                        r.message_end = 1'b1;
                        clear_parse();
                    end
                end
                default:
                begin
                    if (header_bytes == 0)
                    begin
                        name_shift = '0;
                    end
                    name_shift = {name_shift[NAME_W-BYTE_W-1:0], it.stream_byte};
                    header_bytes++;
                    if (header_bytes >= TYPE_BYTES)
                    begin
                        header_bytes = 0;
                        matched = lookup_type(name_shift);
                        if (matched == '0)
                        begin
                            r.error_code = ERR_UNKNOWN_TYPE;
                            r.in_error   = 1'b1;
                            parse_phase  = HOLD_ERROR;
                        end
                        else
                        begin
                            active_type    = matched;
                            r.message_type = matched;
                            declared_len   = '0;
                            received_len   = '0;
                            parse_phase    = SEEK_LENGTH;
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t predicted;
        result_t want;
        if (!rst_n)
        begin
            slots_enabled = '0;
            for (int i = 0; i < NAME_REGS; i++)
            begin
                type_names[i] = '0;
            end
            payload_cap = MAX_PAYLOAD_RESET;
            clear_parse();
            awaited_results.delete();
            failures        = 0;
            pending         = 0;
            results_checked = 0;
            messages_ended  = 0;
        end
        else
        begin
            if (write_enable)
            begin
                case (write_index)
                    REG_TYPE_COUNT:      slots_enabled = write_data[2:0];
                    REG_TYPE_NAME_ONE:   type_names[0] = write_data[NAME_W-1:0];
                    REG_TYPE_NAME_TWO:   type_names[1] = write_data[NAME_W-1:0];
                    REG_TYPE_NAME_THREE: type_names[2] = write_data[NAME_W-1:0];
                    REG_TYPE_NAME_FOUR:  type_names[3] = write_data[NAME_W-1:0];
                    REG_MAX_PAYLOAD:     payload_cap   = write_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (item_valid && item_ready)
            begin
                deframe_byte(item, predicted);
                awaited_results.push_back(predicted);
            end
            if (result_valid && result_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    failures++;
                    $display("%0t: result with none expected, expected nothing, actual %0h",
                             $time, result);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("payload_valid", 8'(want.payload_valid), 8'(result.payload_valid));
                    check_field("payload_byte", want.payload_byte, result.payload_byte);
                    check_field("message_type", 8'(want.message_type), 8'(result.message_type));
                    check_field("message_end", 8'(want.message_end), 8'(result.message_end));
                    check_field("error_code", 8'(want.error_code), 8'(result.error_code));
                    check_field("in_error", 8'(want.in_error), 8'(result.in_error));
                    results_checked++;
                    if (want.message_end)
                    begin
                        messages_ended++;
                    end
                end
            end
            pending = awaited_results.size();
        end
    end

endmodule

// ----- bench/type_length_value_deframer_tb.sv -----
// Top of the deframer testbench: clock, reset, register writes, framed byte stimulus
// with bursty sending and patterned receive stalls, and the final verdict.
// Depends on tld_pkg, type_length_value_deframer and type_length_value_deframer_checker.
module type_length_value_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tld_pkg::*;

    localparam int ITEM_TARGET = 1050;
    localparam int PHASE_ITEMS = 140;
    localparam int CYCLE_LIMIT = 500000;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               write_enable = 1'b0;
    logic [INDEX_W-1:0] write_index  = REG_TYPE_COUNT;
    logic [DATA_W-1:0]  write_data   = '0;
    logic               item_valid   = 1'b0;
    logic               item_ready;
    item_t              item         = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    result_t            result;

    int failures;
    int pending;
    int results_checked;
    int messages_ended;

    logic [2:0]        slot_count;
    logic [NAME_W-1:0] name_words [NAME_REGS];
    logic [LEN_W-1:0]  payload_cap;
    int                items_sent;
    int                burst_left;
    int                settings_used;
    int                cycles = 0;

    logic [31:0] ready_pattern = '0;
    logic [4:0]  ready_pos     = '0;

    type_length_value_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    type_length_value_deframer_checker scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .write_enable    (write_enable),
        .write_index     (write_index),
        .write_data      (write_data),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item            (item),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result),
        .failures        (failures),
        .pending         (pending),
        .results_checked (results_checked),
        .messages_ended  (messages_ended)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Run stopped at cycle limit with %0d results outstanding.", pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (ready_pos == '0)
        begin
            case ($urandom_range(0, 3))
                0:       ready_pattern = '1;
                1:       ready_pattern = $urandom | 32'h1;
                2:       ready_pattern = 32'h5555_5555;
                default: ready_pattern = $urandom | $urandom;
            endcase
        end
        result_ready = ready_pattern[ready_pos] | (ready_pattern == '0);
        ready_pos++;
    end

    task automatic send_item(input logic [7:0] b, input logic rs, input bit counted);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        item.stream_byte = b;
        item.restart     = rs;
        item_valid       = 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
        burst_left--;
        if (counted)
        begin
            items_sent++;
        end
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
        begin
            send_item(w[8*i +: 8], 1'b0, 1'b1);
        end
    endtask

    task automatic wait_idle();
        item_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
        write_enable = 1'b1;
        write_index  = idx;
        write_data   = data;
        @(negedge clk);
        write_enable = 1'b0;
    endtask

    task automatic configure(input int setting);
        logic [NAME_W-1:0] word;
        for (int i = 0; i < NAME_REGS; i++)
        begin
            case ($urandom_range(0, 3))
                0:       word = $urandom;
                1:       word = $urandom >> (8 * $urandom_range(1, 3));
                2:       word = (i > 0) ? name_words[$urandom_range(0, i - 1)] : '1;
                default: word = $urandom_range(0, 1) ? '0 : '1;
            endcase
            name_words[i] = word;
            write_reg(INDEX_W'(REG_TYPE_NAME_ONE + i), word);
        end
        case (setting % 8)
            2:       slot_count = 3'd7;
            3:       slot_count = 3'd0;
            default: slot_count = 3'($urandom_range(1, TYPE_SLOTS));
        endcase
        case (setting % 8)
            0:       payload_cap = '0;
            1:       payload_cap = '1;
            4:       payload_cap = 40;
            default: payload_cap = $urandom_range(1, 24);
        endcase
        write_reg(REG_TYPE_COUNT, DATA_W'(slot_count));
        write_reg(REG_MAX_PAYLOAD, payload_cap);
        settings_used++;
    endtask

    task automatic send_message();
        int                kind;
        int                slots;
        int                pick;
        int                total;
        int                cut;
        int                header_len;
        bit                matched;
        bit                failing;
        logic [NAME_W-1:0] name;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  limit;
        logic [7:0]        b;
        kind  = $urandom_range(0, 99);
        slots = (slot_count > TYPE_SLOTS) ? TYPE_SLOTS : int'(slot_count);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 8))
            begin
                send_item(8'($urandom), $urandom_range(0, 7) == 0, 1'b1);
            end
            send_item(8'($urandom), 1'b1, 1'b1);
        end
        else
        begin
            name  = (kind < 20 || slots == 0) ? $urandom : name_words[$urandom_range(0, slots - 1)];
            limit = (payload_cap < 12) ? payload_cap : 12;
            pick  = $urandom_range(0, 19);
            if (pick == 0 && payload_cap != '1)
                len = payload_cap + 1 + $urandom_range(0, 3);
            else if (pick == 1 && payload_cap != '1)
                len = '1;
            else if (pick == 2 && payload_cap <= 40)
                len = payload_cap;
            else if (pick == 3)
                len = '0;
            else
                len = $urandom_range(0, limit);
            matched = 1'b0;
            for (int i = 0; i < slots; i++)
            begin
                if (name_words[i] == name)
                begin
                    matched = 1'b1;
                end
            end
            header_len = matched ? TYPE_BYTES + LENGTH_BYTES : TYPE_BYTES;
            failing    = !matched || len > payload_cap;
            total      = failing ? header_len : header_len + int'(len);
            cut        = (kind < 30) ? $urandom_range(0, total - 1) : -1;
            for (int pos = 0; pos < total; pos++)
            begin
                if (pos == cut)
                begin
                    send_item(8'($urandom), 1'b1, 1'b1);
                    return;
                end
                if (pos < TYPE_BYTES)
                    b = name[8 * (TYPE_BYTES - 1 - pos) +: 8];
                else if (pos < TYPE_BYTES + LENGTH_BYTES)
                    b = len[8 * (TYPE_BYTES + LENGTH_BYTES - 1 - pos) +: 8];
                else
                    b = 8'($urandom);
                send_item(b, 1'b0, 1'b1);
            end
            if (failing)
            begin
                repeat ($urandom_range(0, 3))
                begin
                    send_item(8'($urandom), 1'b0, 1'b0);
                end
                send_item(8'($urandom), 1'b1, 1'b1);
            end
        end
    endtask

    initial
    begin
        int setting;
        int phase_end;
        slot_count    = '0;
        payload_cap   = MAX_PAYLOAD_RESET;
        items_sent    = 0;
        burst_left    = 0;
        settings_used = 0;
        for (int i = 0; i < NAME_REGS; i++)
        begin
            name_words[i] = '0;
        end
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_word(32'h0000_0000);
        send_item(8'h00, 1'b1, 1'b1);
        wait_idle();

        name_words[0] = 32'h4142_4344;
        name_words[1] = 32'h0000_4142;
        name_words[2] = 32'hFFFF_FFFF;
        name_words[3] = 32'h0000_0000;
        for (int i = 0; i < NAME_REGS; i++)
        begin
            write_reg(INDEX_W'(REG_TYPE_NAME_ONE + i), name_words[i]);
        end
        slot_count  = 3'd4;
        payload_cap = 1;
        write_reg(REG_TYPE_COUNT, DATA_W'(slot_count));
        write_reg(REG_MAX_PAYLOAD, payload_cap);
        settings_used++;

        send_word(name_words[0]);
        send_word(32'd1);
        send_item(8'h00, 1'b0, 1'b1);
        send_word(name_words[3]);
        send_word(32'd0);
        send_word(name_words[2]);
        send_word(32'hFFFF_FFFF);
        send_item(8'hFF, 1'b1, 1'b1);

        setting = 0;
        while (items_sent < ITEM_TARGET)
        begin
            wait_idle();
            configure(setting);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < ITEM_TARGET)
            begin
                send_message();
            end
            setting++;
        end

        wait_idle();
        repeat (8) @(negedge clk);
        $display("Sent %0d stream bytes under %0d register settings, with restarts, unknown types,",
                 items_sent, settings_used);
        $display("oversize lengths and zero lengths; %0d results compared, %0d messages ended.",
                 results_checked, messages_ended);
        if (failures == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
